### hdl/sfc_pkg.sv
// shared types, constants and the crc-8 byte update for the serial frame checker
// no dependencies; used by every module of the block by scoped names

package sfc_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned COUNT_W     = 7;
   localparam int unsigned MAX_LEN_W   = 7;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned RSP_DATA_W  = 32;

   localparam logic [COUNT_W-1:0]   MIN_TOTAL_LEN = 7'd4;
   localparam logic [COUNT_W-1:0]   MAX_TOTAL_LEN = 7'd64;
   localparam logic [COUNT_W-1:0]   COUNT_SAT     = 7'd65;

   localparam logic [BYTE_W-1:0]    RESET_POLY      = 8'd213;
   localparam logic [BYTE_W-1:0]    RESET_CTRL_ADDR = 8'd200;
   localparam logic [BYTE_W-1:0]    RESET_RC_TYPE   = 8'd22;
   localparam logic [MAX_LEN_W-1:0] RESET_MAX_LEN   = 7'd64;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_LENGTH    = 2'd1,
      ERR_LEN_FIELD = 2'd2,
      ERR_CRC       = 2'd3
   } error_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CRC_POLY  = 2'd0,
      CSR_CTRL_ADDR = 2'd1,
      CSR_RC_TYPE   = 2'd2,
      CSR_MAX_LEN   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    crc_poly;
      logic [BYTE_W-1:0]    ctrl_addr;
      logic [BYTE_W-1:0]    rc_type;
      logic [MAX_LEN_W-1:0] max_len;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] byte_count;
      logic [BYTE_W-1:0]  crc_running;
      logic [BYTE_W-1:0]  saved_address;
      logic [BYTE_W-1:0]  saved_length;
      logic [BYTE_W-1:0]  saved_type;
   } frame_state_type;

   typedef struct packed {
      logic               frame_ok;
      error_code_type     error_code;
      logic [BYTE_W-1:0]  dest_address;
      logic [BYTE_W-1:0]  frame_kind;
      logic [BYTE_W-1:0]  length_byte;
      logic               is_rc_channels;
   } result_type;

   // msb-first crc-8, one byte in eight shift steps
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data,
                                                   input logic [BYTE_W-1:0] poly);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ poly;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### hdl/sfc_frame_track.sv
// per-frame state: byte count, running crc and the three header bytes
// depends on sfc_pkg

module sfc_frame_track (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_valid,
   input  logic [7:0]               rx_byte,
   input  logic                     end_of_frame,
   input  logic [7:0]               crc_poly,
   output sfc_pkg::frame_state_type state
);

   logic [sfc_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [sfc_pkg::BYTE_W-1:0]  crc_ff, crc_in;
   logic [sfc_pkg::BYTE_W-1:0]  address_ff, address_in;
   logic [sfc_pkg::BYTE_W-1:0]  length_ff, length_in;
   logic [sfc_pkg::BYTE_W-1:0]  type_ff, type_in;

   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      address_in    = address_ff;
      length_in     = length_ff;
      type_in       = type_ff;
      if (byte_valid) begin
         if (end_of_frame) begin
            // frame done, back to the cleared state
            byte_count_in = '0;
            crc_in        = '0;
            address_in    = '0;
            length_in     = '0;
            type_in       = '0;
         end else begin
            if (byte_count_ff == 7'd0) address_in = rx_byte;
            if (byte_count_ff == 7'd1) length_in  = rx_byte;
            if (byte_count_ff == 7'd2) type_in    = rx_byte;
            if (byte_count_ff >= 7'd2 && byte_count_ff < sfc_pkg::COUNT_SAT) begin
               crc_in = sfc_pkg::crc8_byte(crc_ff, rx_byte, crc_poly);
            end
            if (byte_count_ff < sfc_pkg::COUNT_SAT) begin
               byte_count_in = byte_count_ff + 7'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         crc_ff        <= '0;
         address_ff    <= '0;
         length_ff     <= '0;
         type_ff       <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         address_ff    <= address_in;
         length_ff     <= length_in;
         type_ff       <= type_in;
      end
   end

   assign state.byte_count    = byte_count_ff;
   assign state.crc_running   = crc_ff;
   assign state.saved_address = address_ff;
   assign state.saved_length  = length_ff;
   assign state.saved_type    = type_ff;

endmodule

### hdl/sfc_frame_check.sv
// end-of-frame checks: length range, length field and crc against the last byte
// depends on sfc_pkg

module sfc_frame_check (
   input  sfc_pkg::frame_state_type state,
   input  logic [7:0]               rx_byte,
   input  sfc_pkg::cfg_type         cfg,
   output sfc_pkg::result_type      result
);

   logic [sfc_pkg::COUNT_W-1:0] total_len;
   logic [sfc_pkg::COUNT_W-1:0] max_len;
   logic [sfc_pkg::BYTE_W-1:0]  address;
   logic [sfc_pkg::BYTE_W-1:0]  length;
   logic [sfc_pkg::BYTE_W-1:0]  kind;
   logic [sfc_pkg::BYTE_W-1:0]  expected_len;
   sfc_pkg::error_code_type     err;

   always_comb begin
      // the current byte may still be one of the header bytes
      address = (state.byte_count == 7'd0) ? rx_byte : state.saved_address;
      length  = (state.byte_count == 7'd1) ? rx_byte : state.saved_length;
      kind    = (state.byte_count == 7'd2) ? rx_byte : state.saved_type;

      total_len    = state.byte_count + 7'd1;
      max_len      = (cfg.max_len > sfc_pkg::MAX_TOTAL_LEN) ? sfc_pkg::MAX_TOTAL_LEN
                                                             : cfg.max_len;
      expected_len = {1'b0, state.byte_count} - 8'd1;

      if (total_len < sfc_pkg::MIN_TOTAL_LEN || total_len > max_len) begin
         err = sfc_pkg::ERR_LENGTH;
      end else if (length != expected_len) begin
         err = sfc_pkg::ERR_LEN_FIELD;
      end else if (rx_byte != state.crc_running) begin
         err = sfc_pkg::ERR_CRC;
      end else begin
         err = sfc_pkg::ERR_NONE;
      end

      result.frame_ok       = (err == sfc_pkg::ERR_NONE);
      result.error_code     = err;
      result.dest_address   = address;
      result.frame_kind     = kind;
      result.length_byte    = length;
      result.is_rc_channels = (err == sfc_pkg::ERR_NONE) && (address == cfg.ctrl_addr)
                              && (kind == cfg.rc_type);
   end

endmodule

### hdl/serial_frame_checker_crc8.sv
// top level of the serial frame checker: configuration registers, stream handshake
// and the result register; depends on sfc_pkg, sfc_frame_track and sfc_frame_check

// Frame bytes arrive one transfer at a time on the req_ stream, with req_tlast
// marking the last byte before line idle. Byte 0 is the destination address,
// byte 1 the length field, byte 2 the frame type and the last byte the crc-8
// (msb first, init zero) over byte 2 up to the byte before the last. Every
// last byte yields exactly one result transfer on rsp_; other bytes yield none.
// One byte is taken every cycle: the crc update and all checks sit in one
// combinational step between the frame state registers and the result
// register, so a byte is accepted on the same cycle as it is offered unless
// the result register still holds a result that rsp_ has not taken. A result
// appears on rsp_ in the cycle after its last byte is taken. Frames shorter than four
// bytes, longer than max_len (capped at 64) or longer than 64 fail with error code 1;
// then a wrong length field gives 2 and a wrong crc gives 3. Configuration is to be
// written through csr_ only while no frame is in progress; the block does not enforce it.

module serial_frame_checker_crc8 (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // end_of_frame
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] frame_ok, [2:1] error_code, [10:3] dest_address,
                                    // [18:11] frame_kind, [26:19] length_byte,
                                    // [27] is_rc_channels, [31:28] zero
   // configuration writes
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   sfc_pkg::cfg_type         cfg_ff, cfg_in;
   sfc_pkg::frame_state_type frame_state;
   sfc_pkg::result_type      check_result;
   sfc_pkg::result_type      result_ff, result_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_transfer;

   // configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (sfc_pkg::csr_index_type'(csr_index))
            sfc_pkg::CSR_CRC_POLY:  cfg_in.crc_poly  = csr_wdata;
            sfc_pkg::CSR_CTRL_ADDR: cfg_in.ctrl_addr = csr_wdata;
            sfc_pkg::CSR_RC_TYPE:   cfg_in.rc_type   = csr_wdata;
            sfc_pkg::CSR_MAX_LEN:   cfg_in.max_len   = csr_wdata[sfc_pkg::MAX_LEN_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_poly  <= sfc_pkg::RESET_POLY;
         cfg_ff.ctrl_addr <= sfc_pkg::RESET_CTRL_ADDR;
         cfg_ff.rc_type   <= sfc_pkg::RESET_RC_TYPE;
         cfg_ff.max_len   <= sfc_pkg::RESET_MAX_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a byte may enter whenever the result register is free or being emptied
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_transfer = req_tvalid && req_tready;

   sfc_frame_track u_track (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_transfer),
      .rx_byte      (req_tdata),
      .end_of_frame (req_tlast),
      .crc_poly     (cfg_ff.crc_poly),
      .state        (frame_state)
   );

   sfc_frame_check u_check (
      .state   (frame_state),
      .rx_byte (req_tdata),
      .cfg     (cfg_ff),
      .result  (check_result)
   );

   // result register: loaded by the last byte of a frame
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_transfer && req_tlast) begin
         rsp_valid_in = 1'b1;
         result_in    = check_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        result_ff.is_rc_channels,
                        result_ff.length_byte,
                        result_ff.frame_kind,
                        result_ff.dest_address,
                        result_ff.error_code,
                        result_ff.frame_ok};

endmodule

### tb/frame_check_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the serial frame checker: byte-level frame predictor and result queue
// depends on sfc_pkg for the result layout, error codes and register indexes

package frame_check_pkg;

   import sfc_pkg::*;

   class frame_scoreboard;

      // register copies
      logic [7:0] poly;
      logic [7:0] ctrl_addr;
      logic [7:0] rc_type;
      logic [6:0] max_len;

      // frame in progress
      logic [6:0] count;
      logic [7:0] crc_now;
      logic [7:0] crc_prev;
      logic [7:0] addr_seen;
      logic [7:0] len_seen;
      logic [7:0] kind_seen;

      result_type  expected_q[$];
      int unsigned failures;
      int unsigned frames_checked;
      int unsigned rc_frames;
      int unsigned err_seen[4];

      function new();
         poly      = RESET_POLY;
         ctrl_addr = RESET_CTRL_ADDR;
         rc_type   = RESET_RC_TYPE;
         max_len   = RESET_MAX_LEN;
         clear_frame();
      endfunction

      function void clear_frame();
         count     = '0;
         crc_now   = '0;
         crc_prev  = '0;
         addr_seen = '0;
         len_seen  = '0;
         kind_seen = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_CRC_POLY:  poly      = value;
            CSR_CTRL_ADDR: ctrl_addr = value;
            CSR_RC_TYPE:   rc_type   = value;
            CSR_MAX_LEN:   max_len   = value[6:0];
            default: ;
         endcase
      endfunction

      function int effective_max();
         return (max_len > MAX_TOTAL_LEN) ? int'(MAX_TOTAL_LEN) : int'(max_len);
      endfunction

      // bit-serial form: feedback is the top crc bit xor the next data bit
      function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] data);
         logic [7:0] c;
         logic       fb;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
               c = c ^ poly;
            end
         end
         return c;
      endfunction

      function void note_byte(logic [7:0] data, logic last);
         int         idx;
         int         total;
         result_type want;
         idx = count;
         if (idx == 0) begin
            addr_seen = data;
         end else if (idx == 1) begin
            len_seen = data;
         end else if (idx == 2) begin
            kind_seen = data;
         end
         if (idx >= 2 && idx < COUNT_SAT) begin
            crc_prev = crc_now;
            crc_now  = crc_step(crc_now, data);
         end
         if (count < COUNT_SAT) begin
            count = count + 7'd1;
         end
         if (!last) begin
            return;
         end
         total = idx + 1;
         if (total < MIN_TOTAL_LEN || total > effective_max()) begin
            want.error_code = ERR_LENGTH;
         end else if (int'(len_seen) != total - 2) begin
            want.error_code = ERR_LEN_FIELD;
         end else if (data != crc_prev) begin
            want.error_code = ERR_CRC;
         end else begin
            want.error_code = ERR_NONE;
         end
         want.frame_ok       = (want.error_code == ERR_NONE);
         want.dest_address   = addr_seen;
         want.frame_kind     = kind_seen;
         want.length_byte    = len_seen;
         want.is_rc_channels = want.frame_ok && addr_seen == ctrl_addr && kind_seen == rc_type;
         expected_q.push_back(want);
         clear_frame();
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit field_differs(string label, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void check_result(logic [31:0] word);
         result_type want;
         bit         bad;
         if (expected_q.size() == 0) begin
            $display("%0t: result transfer with no frame outstanding, expected none actual %h",
                     $time, word);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         bad  = 1'b0;
         bad |= field_differs("frame_ok", want.frame_ok, word[0]);
         bad |= field_differs("error_code", want.error_code, word[2:1]);
         bad |= field_differs("dest_address", want.dest_address, word[10:3]);
         bad |= field_differs("frame_kind", want.frame_kind, word[18:11]);
         bad |= field_differs("length_byte", want.length_byte, word[26:19]);
         bad |= field_differs("is_rc_channels", want.is_rc_channels, word[27]);
         bad |= field_differs("padding", 8'd0, {4'd0, word[31:28]});
         if (bad) begin
            failures++;
         end
         frames_checked++;
         err_seen[want.error_code]++;
         if (want.is_rc_channels) begin
            rc_frames++;
         end
      endfunction

   endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// top-level testbench for serial_frame_checker_crc8: drives frames, configures, checks results
// depends on sfc_pkg, frame_check_pkg and the block itself

module tb_top;

   import sfc_pkg::*;
   import frame_check_pkg::*;

   typedef enum int {
      FLAW_NONE,
      FLAW_LEN_FIELD,
      FLAW_CRC,
      FLAW_BOTH
   } frame_flaw_type;

   localparam int SEG_N = 7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] rx_byte
   logic        req_tlast  = 1'b0;   // end_of_frame
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [0] frame_ok, [2:1] error_code, [10:3] dest_address,
                                    // [18:11] frame_kind, [26:19] length_byte,
                                    // [27] is_rc_channels, [31:28] zero
   logic        csr_wr_en  = 1'b0;
   logic [1:0]  csr_index  = CSR_CRC_POLY;
   logic [7:0]  csr_wdata  = 8'd0;

   // percentage of cycles in which each side holds back
   int unsigned send_idle = 15;
   int unsigned recv_idle = 51;
   int unsigned byte_transfers = 0;

   // register settings per random segment; the last one is drawn at run time
   logic [7:0] seg_poly  [SEG_N] = '{8'h07, 8'hFF, 8'h00, 8'h31, 8'h80, 8'hD5, 8'h00};
   logic [7:0] seg_addr  [SEG_N] = '{8'h00, 8'hFF, 8'hA5, 8'h12, 8'h01, 8'hC8, 8'h00};
   logic [7:0] seg_kind  [SEG_N] = '{8'hFF, 8'h00, 8'h5A, 8'h34, 8'h80, 8'h16, 8'h00};
   logic [7:0] seg_max   [SEG_N] = '{8'd64, 8'd4, 8'd127, 8'd2, 8'd200, 8'd20, 8'd64};
   int         seg_items [SEG_N] = '{200, 120, 180, 60, 180, 180, 180};

   frame_scoreboard sb = new();

   serial_frame_checker_crc8 u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // every result transfer is checked against the oldest outstanding frame
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         sb.check_result(rsp_tdata);
      end
   end

   // offer one byte, optionally after some idle cycles, and wait for the transfer
   task automatic put_byte(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_byte(data, last);
      byte_transfers++;
      @(negedge clock);
   endtask

   // hold the sender until every outstanding frame has produced its result and been checked
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] poly, input logic [7:0] addr,
                                input logic [7:0] kind, input logic [7:0] max_value);
      write_reg(CSR_CRC_POLY, poly);
      write_reg(CSR_CTRL_ADDR, addr);
      write_reg(CSR_RC_TYPE, kind);
      write_reg(CSR_MAX_LEN, max_value);
      csr_wr_en <= 1'b0;
   endtask

   // build a frame of the given total length; from four bytes on the length field
   // and trailing crc are made correct first and then spoilt as the flaw asks
   task automatic send_frame(input int total, input frame_flaw_type flaw,
                             input logic [7:0] dest, input logic [7:0] kind);
      logic [7:0] frame_bytes[$];
      logic [7:0] crc;
      for (int i = 0; i < total; i++) begin
         frame_bytes.push_back(8'($urandom_range(255)));
      end
      frame_bytes[0] = dest;
      if (total > 2) begin
         frame_bytes[2] = kind;
      end
      if (total >= 4) begin
         frame_bytes[1] = 8'(total - 2);
         if (flaw == FLAW_LEN_FIELD || flaw == FLAW_BOTH) begin
            frame_bytes[1] ^= 8'($urandom_range(1, 255));
         end
         crc = 8'd0;
         for (int i = 2; i < total - 1; i++) begin
            crc = sb.crc_step(crc, frame_bytes[i]);
         end
         frame_bytes[total-1] = crc;
         if (flaw == FLAW_CRC || flaw == FLAW_BOTH) begin
            frame_bytes[total-1] ^= 8'($urandom_range(1, 255));
         end
      end
      for (int i = 0; i < total; i++) begin
         put_byte(frame_bytes[i], i == total - 1);
      end
   endtask

   // mostly short well-formed frames, with some long ones, runts, oversize
   // frames, some running past the count saturation, and broken length or crc
   task automatic random_frame();
      int             hi;
      int             r;
      int             total;
      frame_flaw_type flaw;
      logic [7:0]     dest;
      logic [7:0]     kind;
      hi = sb.effective_max();
      if (hi < 4) begin
         hi = 12;
      end
      r = $urandom_range(99);
      if (r < 72) begin
         total = $urandom_range(4, (hi < 12) ? hi : 12);
      end else if (r < 88) begin
         total = $urandom_range(4, hi);
      end else if (r < 94) begin
         total = $urandom_range(1, 3);
      end else begin
         total = $urandom_range(hi + 1, 70);
      end
      r = $urandom_range(99);
      if (r < 70) begin
         flaw = FLAW_NONE;
      end else if (r < 82) begin
         flaw = FLAW_CRC;
      end else if (r < 92) begin
         flaw = FLAW_LEN_FIELD;
      end else begin
         flaw = FLAW_BOTH;
      end
      dest = ($urandom_range(99) < 35) ? sb.ctrl_addr : 8'($urandom_range(255));
      kind = ($urandom_range(99) < 35) ? sb.rc_type : 8'($urandom_range(255));
      send_frame(total, flaw, dest, kind);
   endtask

   initial begin
      int target;
      target = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames under the reset register values
      send_frame(4, FLAW_NONE, 8'd200, 8'd22);       // minimal good rc channels frame
      send_frame(5, FLAW_NONE, 8'hFF, 8'h00);        // good frame, not for the controller
      put_byte(8'hFF, 1'b1);                         // one-byte runt, unseen fields read zero
      put_byte(8'h00, 1'b0);                         // two-byte runt
      put_byte(8'hFF, 1'b1);
      send_frame(3, FLAW_NONE, 8'h55, 8'hAA);        // three-byte runt
      send_frame(4, FLAW_LEN_FIELD, 8'd200, 8'd22);  // wrong length field
      send_frame(4, FLAW_CRC, 8'h00, 8'hFF);         // wrong crc only
      wait_drain();

      for (int seg = 0; seg < SEG_N; seg++) begin
         // idling: sender light and receiver heavy, then swapped, then none
         if (seg < 2) begin
            send_idle = 15;
            recv_idle = 51;
         end else if (seg < 4) begin
            send_idle = 51;
            recv_idle = 15;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (seg == SEG_N - 1) begin
            seg_poly[seg] = 8'($urandom_range(255));
            seg_addr[seg] = 8'($urandom_range(255));
            seg_kind[seg] = 8'($urandom_range(255));
            seg_max[seg]  = 8'($urandom_range(4, 64));
         end
         apply_setting(seg_poly[seg], seg_addr[seg], seg_kind[seg], seg_max[seg]);
         target += seg_items[seg];
         while (byte_transfers < target) begin
            random_frame();
            if ($urandom_range(99) < 2) begin
               wait_drain();
            end
         end
         wait_drain();
      end

      $display("covered %0d byte transfers, %0d frames (%0d rc channels) over %0d settings",
               byte_transfers, sb.frames_checked, sb.rc_frames, SEG_N + 1);
      $display("outcomes: ok %0d, length %0d, length field %0d, crc %0d",
               sb.err_seen[ERR_NONE], sb.err_seen[ERR_LENGTH],
               sb.err_seen[ERR_LEN_FIELD], sb.err_seen[ERR_CRC]);
      if (sb.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("TEST FAILED");
      $finish;
   end

endmodule
